[rtl/gewh_pkg.sv]
// ----------------------------------------------------------------------------
// gewh_pkg
// Shared types and constants for the gated envelope with hold block.
// ----------------------------------------------------------------------------
package gewh_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int COEFF_FRAC_BITS_DEF = 24;
    localparam int HOLD_BITS_DEF       = 18;

    // key threshold register is fixed width
    localparam int THRESH_BITS = 23;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_LEVEL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_SAMPLES    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_COEFF    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_COEFF   = 3'd4;

    // register reset values, masked to width where used
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 23'd83886;
    localparam logic [31:0]            HOLD_RESET      = 32'd9600;
    localparam logic [31:0]            ATTACK_RESET    = 32'd16707460;
    localparam logic [31:0]            RELEASE_RESET   = 32'd16773721;

    // per-request command from the front end to the gain/scale back end
    typedef struct packed {
        logic bypass;   // gate disabled: pass wet samples, leave gain alone
        logic open;     // target gain is 1.0
    } gewh_cmd_t;

    localparam int CMD_BITS = $bits(gewh_cmd_t);

endpackage

[rtl/gewh_fifo.sv]
// ----------------------------------------------------------------------------
// gewh_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gewh_fifo
    import gewh_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/gewh_front.sv]
// ----------------------------------------------------------------------------
// gewh_front
// Takes input frames, derives the key, runs the hold counter and decides
// the gain target and coefficient for each request.
// ----------------------------------------------------------------------------
module gewh_front
    import gewh_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    parameter int HOLD_BITS       = HOLD_BITS_DEF,
    localparam int QW             = CMD_BITS + COEFF_FRAC_BITS + 2 * SAMPLE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       gate_enable,
    input  logic [THRESH_BITS-1:0]     threshold_level,
    input  logic [HOLD_BITS-1:0]       hold_samples,
    input  logic [COEFF_FRAC_BITS-1:0] attack_coeff,
    input  logic [COEFF_FRAC_BITS-1:0] release_coeff,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_dry_left,
    input  logic signed [SAMPLE_BITS-1:0] s_dry_right,
    input  logic signed [SAMPLE_BITS-1:0] s_wet_left,
    input  logic signed [SAMPLE_BITS-1:0] s_wet_right,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [QW-1:0]              q_data
);

    localparam int CW = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    logic [HOLD_BITS-1:0]       hold_count_reg, hold_count_next;
    logic [SAMPLE_BITS-1:0]     mag_l, mag_r, key;
    logic                       above;
    gewh_cmd_t                  cmd;
    logic [COEFF_FRAC_BITS-1:0] coeff;
    logic                       accept;

    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && q_ready;

    // two's complement magnitude; full-scale negative reads as 2^(N-1)
    assign mag_l = s_dry_left[SAMPLE_BITS-1]  ? (~s_dry_left  + 1'b1) : s_dry_left;
    assign mag_r = s_dry_right[SAMPLE_BITS-1] ? (~s_dry_right + 1'b1) : s_dry_right;
    assign key   = (mag_r > mag_l) ? mag_r : mag_l;
    assign above = CW'(key) > CW'(threshold_level);

    always_comb begin
        hold_count_next = hold_count_reg;
        cmd.bypass      = !gate_enable;
        cmd.open        = 1'b0;
        if (above) begin
            hold_count_next = hold_samples;
            cmd.open        = 1'b1;
        end else if (hold_count_reg != '0) begin
            hold_count_next = hold_count_reg - 1'b1;
            cmd.open        = 1'b1;
        end
        // opening at full gain lands on 1.0 whatever the coefficient
        coeff = cmd.open ? attack_coeff : release_coeff;
    end

    assign q_data = {cmd, coeff, s_wet_left, s_wet_right};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_count_reg <= '0;
        end else if (accept && gate_enable) begin
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

[rtl/gewh_back.sv]
// ----------------------------------------------------------------------------
// gewh_back
// Gain recurrence and wet sample scaling. One stage updates the gain,
// the next multiplies both wet samples into the output register.
// ----------------------------------------------------------------------------
module gewh_back
    import gewh_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    localparam int QW             = CMD_BITS + COEFF_FRAC_BITS + 2 * SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [QW-1:0]                 q_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_gated_left,
    output logic signed [SAMPLE_BITS-1:0] m_gated_right
);

    localparam int F  = COEFF_FRAC_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + F + 2;
    localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};

    gewh_cmd_t         q_cmd;
    logic [F-1:0]      q_coeff;
    logic [SB-1:0]     q_wl, q_wr;

    logic [F:0]        gain_reg, gain_next;
    logic [F:0]        mul_op;
    logic [2*F:0]      mul_p;
    logic [2*F+1:0]    mul_rnd;

    logic              s1_valid_reg;
    logic              s1_bypass_reg;
    logic [SB-1:0]     s1_wl_reg, s1_wr_reg;
    logic              s1_move;
    logic              pop;

    logic              m_valid_reg;
    logic [SB-1:0]     m_left_reg, m_right_reg;
    logic [SB-1:0]     scaled_l, scaled_r;

    assign {q_cmd, q_coeff, q_wl, q_wr} = q_data;

    assign s1_move = s1_valid_reg && (!m_valid_reg || m_ready);
    assign q_ready = !s1_valid_reg || s1_move;
    assign pop     = q_valid && q_ready;

    // closing: c*g >> F; opening: one - ceil(c*(one-g) / one)
    always_comb begin
        mul_op  = q_cmd.open ? (GAIN_ONE - gain_reg) : gain_reg;
        mul_p   = {{(F+1){1'b0}}, q_coeff} * {{F{1'b0}}, mul_op};
        mul_rnd = {1'b0, mul_p} + {{(F+2){1'b0}}, {F{1'b1}}};
        if (q_cmd.open) begin
            gain_next = GAIN_ONE - mul_rnd[2*F:F];
        end else begin
            gain_next = mul_p[2*F:F];
        end
    end

    function automatic logic [SB-1:0] scale_sample(logic [SB-1:0] s, logic [F:0] g);
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] shifted;
        logic [SB-1:0]        res;
        prod    = PW'($signed(s)) * PW'($signed({1'b0, g}));
        shifted = prod >>> F;
        // saturate when the upper bits do not all match the sign
        if ((&shifted[PW-1:SB-1]) || !(|shifted[PW-1:SB-1])) begin
            res = shifted[SB-1:0];
        end else if (shifted[PW-1]) begin
            res = {1'b1, {(SB-1){1'b0}}};
        end else begin
            res = {1'b0, {(SB-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        scaled_l = s1_bypass_reg ? s1_wl_reg : scale_sample(s1_wl_reg, gain_reg);
        scaled_r = s1_bypass_reg ? s1_wr_reg : scale_sample(s1_wr_reg, gain_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_ONE;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop && !q_cmd.bypass) begin
                gain_reg <= gain_next;
            end
            if (pop) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_bypass_reg <= q_cmd.bypass;
            s1_wl_reg     <= q_wl;
            s1_wr_reg     <= q_wr;
        end
        if (s1_move) begin
            m_left_reg  <= scaled_l;
            m_right_reg <= scaled_r;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_gated_left  = m_left_reg;
    assign m_gated_right = m_right_reg;

endmodule

[rtl/gated_envelope_with_hold_top.sv]
// ----------------------------------------------------------------------------
// gated_envelope_with_hold_top
// Noise gate with attack, hold and release on a stereo wet signal, keyed by
// the dry signal.
// ----------------------------------------------------------------------------
// Sustains one stereo frame per clock while the output is not stalled; a frame
// passes through queue entry, gain update and wet scaling in turn. The rate
// is set by the gain loop: one coefficient multiply and add from the gain
// register back to itself per frame, ahead of the wet multipliers. A two-entry
// queue sits between the key/hold front end and the gain back end, and a
// waiting result does not stop new frames while there is queue space.
// Configuration must be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module gated_envelope_with_hold_top
    import gewh_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    parameter int HOLD_BITS       = HOLD_BITS_DEF,
    localparam int CFG_W0         = (HOLD_BITS > THRESH_BITS) ? HOLD_BITS : THRESH_BITS,
    localparam int CFG_DATA_BITS  = (COEFF_FRAC_BITS > CFG_W0) ? COEFF_FRAC_BITS : CFG_W0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_dry_left,
    input  logic signed [SAMPLE_BITS-1:0] s_dry_right,
    input  logic signed [SAMPLE_BITS-1:0] s_wet_left,
    input  logic signed [SAMPLE_BITS-1:0] s_wet_right,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_gated_left,
    output logic signed [SAMPLE_BITS-1:0] m_gated_right
);

    localparam int QW = CMD_BITS + COEFF_FRAC_BITS + 2 * SAMPLE_BITS;

    logic                       gate_enable_reg;
    logic [THRESH_BITS-1:0]     threshold_level_reg;
    logic [HOLD_BITS-1:0]       hold_samples_reg;
    logic [COEFF_FRAC_BITS-1:0] attack_coeff_reg;
    logic [COEFF_FRAC_BITS-1:0] release_coeff_reg;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          bq_valid, bq_ready;
    logic [QW-1:0] bq_data;

    // register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_enable_reg     <= 1'b0;
            threshold_level_reg <= THRESHOLD_RESET;
            hold_samples_reg    <= HOLD_RESET[HOLD_BITS-1:0];
            attack_coeff_reg    <= ATTACK_RESET[COEFF_FRAC_BITS-1:0];
            release_coeff_reg   <= RELEASE_RESET[COEFF_FRAC_BITS-1:0];
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GATE_ENABLE:     gate_enable_reg     <= cfg_data[0];
                REG_THRESHOLD_LEVEL: threshold_level_reg <= cfg_data[THRESH_BITS-1:0];
                REG_HOLD_SAMPLES:    hold_samples_reg    <= cfg_data[HOLD_BITS-1:0];
                REG_ATTACK_COEFF:    attack_coeff_reg    <= cfg_data[COEFF_FRAC_BITS-1:0];
                REG_RELEASE_COEFF:   release_coeff_reg   <= cfg_data[COEFF_FRAC_BITS-1:0];
                default: ;
            endcase
        end
    end

    gewh_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .HOLD_BITS       (HOLD_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .gate_enable     (gate_enable_reg),
        .threshold_level (threshold_level_reg),
        .hold_samples    (hold_samples_reg),
        .attack_coeff    (attack_coeff_reg),
        .release_coeff   (release_coeff_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dry_left      (s_dry_left),
        .s_dry_right     (s_dry_right),
        .s_wet_left      (s_wet_left),
        .s_wet_right     (s_wet_right),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_data          (fq_data)
    );

    gewh_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    gewh_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (bq_valid),
        .q_ready       (bq_ready),
        .q_data        (bq_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gated_left  (m_gated_left),
        .m_gated_right (m_gated_right)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gated_envelope_with_hold_top. Stereo frames go in
// over a valid/ready request channel with random gaps. A scoreboard keeps its
// own copy of the gate state (gain, hold counter) and the registers, and
// predicts each gated pair. Results are compared in order as they leave the
// block. Directed frames cover the corner cases first. Then randomised
// phases follow, each with its own register setting, made of loud, quiet
// and unconstrained bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gewh_pkg::*;

    localparam int     SB           = SAMPLE_BITS_DEF;
    localparam int     CB           = COEFF_FRAC_BITS_DEF;
    localparam int     HB           = HOLD_BITS_DEF;
    localparam int     CFG_W0       = (HB > THRESH_BITS) ? HB : THRESH_BITS;
    localparam int     CFG_W        = (CB > CFG_W0) ? CB : CFG_W0;
    localparam longint GAIN_ONE     = longint'(1) << CB;
    localparam longint FULL_SCALE   = longint'(1) << (SB - 1);
    localparam int     LIMIT_CYCLES = 200000;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 235;
    localparam int     IDLE_PCT     = 7;

    // index past the register list, must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd5;

    typedef logic signed [SB-1:0] sample_t;
    typedef struct packed {
        sample_t left;
        sample_t right;
    } gated_pair_t;

    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;

    function automatic longint field_mask(int w);
        return (longint'(1) << w) - 1;
    endfunction

    class gate_scoreboard;
        bit          enable;
        longint      threshold;
        longint      hold_len;
        longint      attack_coeff;
        longint      release_coeff;
        longint      gain;
        longint      hold_left;
        gated_pair_t expected_q[$];
        int          errors;

        function new();
            enable        = 1'b0;
            threshold     = longint'(THRESHOLD_RESET);
            hold_len      = longint'(HOLD_RESET) & field_mask(HB);
            attack_coeff  = longint'(ATTACK_RESET) & field_mask(CB);
            release_coeff = longint'(RELEASE_RESET) & field_mask(CB);
            gain          = GAIN_ONE;
            hold_left     = 0;
            errors        = 0;
        endfunction

        function void apply_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_GATE_ENABLE:     enable = data[0];
                REG_THRESHOLD_LEVEL: threshold = longint'(data) & field_mask(THRESH_BITS);
                REG_HOLD_SAMPLES:    hold_len = longint'(data) & field_mask(HB);
                REG_ATTACK_COEFF:    attack_coeff = longint'(data) & field_mask(CB);
                REG_RELEASE_COEFF:   release_coeff = longint'(data) & field_mask(CB);
                default: ;
            endcase
        endfunction

        // wet * gain, floored, then clamped to the sample range
        function sample_t apply_gain(sample_t s, longint g);
            longint sv;
            longint m;
            longint r;
            sv = longint'(s);
            m  = (sv < 0) ? -sv : sv;
            if (sv < 0) begin
                r = -((m * g + GAIN_ONE - 1) >>> CB);
            end else begin
                r = (m * g) >>> CB;
            end
            if (r > FULL_SCALE - 1) r = FULL_SCALE - 1;
            if (r < -FULL_SCALE) r = -FULL_SCALE;
            return r[SB-1:0];
        endfunction

        function void note_request(sample_t dl, sample_t dr, sample_t wl, sample_t wr);
            longint      key_a;
            longint      key_b;
            longint      target;
            longint      coeff;
            gated_pair_t next_pair;
            if (enable) begin
                key_a = longint'(dl);
                key_a = (key_a < 0) ? -key_a : key_a;
                key_b = longint'(dr);
                key_b = (key_b < 0) ? -key_b : key_b;
                if (key_b > key_a) key_a = key_b;
                target = 0;
                if (key_a > threshold) begin
                    hold_left = hold_len;
                    target    = GAIN_ONE;
                end else if (hold_left > 0) begin
                    hold_left--;
                    target = GAIN_ONE;
                end
                coeff = (target > gain) ? attack_coeff : release_coeff;
                if (target == 0) begin
                    gain = (coeff * gain) >>> CB;
                end else begin
                    gain = GAIN_ONE - ((coeff * (GAIN_ONE - gain) + GAIN_ONE - 1) >>> CB);
                end
                next_pair.left  = apply_gain(wl, gain);
                next_pair.right = apply_gain(wr, gain);
            end else begin
                // bypass: state frozen
                next_pair.left  = wl;
                next_pair.right = wr;
            end
            expected_q.push_back(next_pair);
        endfunction

        function void check_result(sample_t gl, sample_t gr);
            gated_pair_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got left %0d right %0d",
                         $time, gl, gr);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (gl !== want.left) begin
                $display("%0t: gated_left expected %0d, got %0d", $time, want.left, gl);
                errors++;
            end
            if (gr !== want.right) begin
                $display("%0t: gated_right expected %0d, got %0d", $time, want.right, gr);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn    = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]          cfg_data   = '0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    sample_t                   s_dry_left  = '0;
    sample_t                   s_dry_right = '0;
    sample_t                   s_wet_left  = '0;
    sample_t                   s_wet_right = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    sample_t                   m_gated_left;
    sample_t                   m_gated_right;
    bit                        calm       = 1'b0;

    gate_scoreboard sb;

    gated_envelope_with_hold_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_dry_left    (s_dry_left),
        .s_dry_right   (s_dry_right),
        .s_wet_left    (s_wet_left),
        .s_wet_right   (s_wet_right),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gated_left  (m_gated_left),
        .m_gated_right (m_gated_right)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_dry_left, s_dry_right, s_wet_left, s_wet_right);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_gated_left, m_gated_right);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.apply_write(idx, data);
        @(posedge aclk);
    endtask

    task automatic send_frame(input sample_t dl, input sample_t dr,
                              input sample_t wl, input sample_t wr);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_dry_left  <= dl;
        s_dry_right <= dr;
        s_wet_left  <= wl;
        s_wet_right <= wr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // loud keys lie above the threshold, quiet ones at or below it
    function automatic sample_t pick_key(bit loud, longint thr);
        longint m;
        if (loud) begin
            m = (thr >= FULL_SCALE - 1) ? FULL_SCALE :
                longint'($urandom_range(int'(thr + 1), int'(FULL_SCALE)));
        end else begin
            m = longint'($urandom_range(0, int'(thr)));
        end
        if (m == FULL_SCALE || $urandom_range(0, 1) == 1) m = -m;
        return m[SB-1:0];
    endfunction

    function automatic sample_t pick_wet();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return r[SB-1:0];
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_coeff();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'(GAIN_ONE - longint'($urandom_range(1, 300000)));
            default: return r[CFG_W-1:0];
        endcase
    endfunction

    task automatic random_config();
        logic [31:0]      r;
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] hold;
        r = $urandom();
        case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = CFG_W'(field_mask(THRESH_BITS));
            2:       thr = CFG_W'($urandom_range(0, 2000));
            default: thr = r[CFG_W-1:0];
        endcase
        case ($urandom_range(0, 5))
            0:       hold = '0;
            1:       hold = CFG_W'(field_mask(HB));
            2, 3, 4: hold = CFG_W'($urandom_range(1, 40));
            default: hold = CFG_W'($urandom_range(0, int'(field_mask(HB))));
        endcase
        // junk in the bits above the register width
        hold = hold | (r[CFG_W-1:0] & ~CFG_W'(field_mask(HB)));
        write_reg(REG_GATE_ENABLE, {r[CFG_W-1:1], ($urandom_range(0, 99) < 85)});
        write_reg(REG_THRESHOLD_LEVEL, thr);
        write_reg(REG_HOLD_SAMPLES, hold);
        write_reg(REG_ATTACK_COEFF, pick_coeff());
        write_reg(REG_RELEASE_COEFF, pick_coeff());
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, r[CFG_W-1:0]);
    endtask

    // bursts of quiet, loud and unconstrained frames
    task automatic random_phase(input int n_items);
        int          sent;
        int          kind;
        int          len;
        sample_t     ka;
        sample_t     kb;
        logic [31:0] r;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            len  = (kind < 45) ? $urandom_range(1, 60) : $urandom_range(1, 30);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if (kind < 45) begin
                    ka = pick_key(1'b0, sb.threshold);
                    kb = pick_key(1'b0, sb.threshold);
                end else if (kind < 85) begin
                    ka = pick_key(1'b1, sb.threshold);
                    kb = pick_key(1'($urandom_range(0, 1)), sb.threshold);
                end else begin
                    r  = $urandom();
                    ka = r[SB-1:0];
                    r  = $urandom();
                    kb = r[SB-1:0];
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_frame(kb, ka, pick_wet(), pick_wet());
                end else begin
                    send_frame(ka, kb, pick_wet(), pick_wet());
                end
                sent++;
            end
        end
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // gate disabled out of reset
        send_frame('0, '0, S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX, SB'(-1), SB'(1));
        drain();

        write_reg(REG_GATE_ENABLE, CFG_W'(1));
        write_reg(REG_THRESHOLD_LEVEL, CFG_W'(1000));
        write_reg(REG_HOLD_SAMPLES, CFG_W'(2));
        write_reg(REG_ATTACK_COEFF, '0);
        write_reg(REG_RELEASE_COEFF, '0);
        write_reg(REG_SPARE, '1);
        // full-scale negative key opens; key equal to threshold only runs hold down
        send_frame(S_MIN, '0, S_MIN, S_MAX);
        send_frame(SB'(1000), SB'(-1000), SB'(12345), SB'(-12345));
        send_frame('0, '0, S_MAX, S_MIN);
        send_frame('0, '0, SB'(-12345), SB'(12345));
        drain();

        // half-way coefficients give fractional gains, checks flooring of negatives
        write_reg(REG_ATTACK_COEFF, CFG_W'(GAIN_ONE / 2));
        write_reg(REG_RELEASE_COEFF, CFG_W'(GAIN_ONE / 2));
        send_frame(SB'(1001), '0, S_MIN, S_MAX);
        send_frame('0, SB'(-1000), SB'(-3), SB'(3));
        send_frame('0, '0, SB'(-3), SB'(3));
        send_frame('0, '0, SB'(-1), SB'(1));
        send_frame('0, '0, S_MIN, S_MAX);
        drain();

        // bypass with a part-open gain, then carry on from the frozen state
        write_reg(REG_GATE_ENABLE, '0);
        send_frame(S_MAX, S_MAX, SB'(-5), SB'(5));
        drain();

        write_reg(REG_GATE_ENABLE, CFG_W'(1));
        write_reg(REG_HOLD_SAMPLES, '0);
        write_reg(REG_THRESHOLD_LEVEL, CFG_W'(field_mask(THRESH_BITS)));
        send_frame(S_MAX, -S_MAX, S_MIN, S_MAX);
        send_frame(S_MIN, '0, S_MIN, S_MAX);
        send_frame('0, S_MAX, S_MIN, S_MAX);
        drain();

        // coefficients next to one barely move the gain
        write_reg(REG_ATTACK_COEFF, '1);
        write_reg(REG_RELEASE_COEFF, '1);
        write_reg(REG_THRESHOLD_LEVEL, '0);
        send_frame(SB'(1), '0, S_MIN, S_MAX);
        send_frame('0, '0, S_MIN, S_MAX);
        send_frame('0, SB'(-1), S_MIN, S_MAX);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm = (p == 3);
            random_config();
            random_phase(PHASE_ITEMS);
        end
        drain();
        calm = 1'b0;
        repeat (8) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
